// ===== design/hbs_pkg.sv =====
package hbs_pkg;

    localparam int HEIGHT_W = 24;
    localparam int POS_W    = 24;
    localparam int IDX_W    = 8;
    localparam int CFG_W    = 8;
    localparam int BANK_AW  = 2 * (IDX_W - 1);
    localparam int NUM_BANK = 4;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic CFG_CELLS_X = 1'b0;
    localparam logic CFG_CELLS_Z = 1'b1;

    localparam logic [CFG_W-1:0] CELLS_RESET = 8'd255;

    typedef struct packed {
        logic                       opcode;
        logic [IDX_W-1:0]           write_col;
        logic [IDX_W-1:0]           write_row;
        logic signed [HEIGHT_W-1:0] height_in;
        logic signed [POS_W-1:0]    query_x;
        logic signed [POS_W-1:0]    query_z;
    } t_req;

    typedef struct packed {
        logic signed [HEIGHT_W-1:0] height_out;
    } t_rsp;

endpackage

// ===== design/hbs_stream_if.sv =====
interface hbs_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/heightmap_bilinear_sampler.sv =====
// Bilinear heightmap sampler.
// Write items give no result; a query passes s1 to s7 and the output register to o_rsp.
// Throughput: one item per cycle while o_rsp is not stalled, writes and queries freely mixed.
// A write lands in the store as it moves from s1 into s2, before any later query reads it.
// Reset (i_rst_n low, synchronous) empties the pipeline and sets both cell counts to 255.
// The height store is not cleared; an entry reads as undefined until it is written.
module heightmap_bilinear_sampler
    import hbs_pkg::*;
#(
    parameter int MAX_CELLS = 255,
    parameter int FRAC_BITS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [CFG_W-1:0]   i_cfg_data,
    hbs_stream_if.sink         i_req,
    hbs_stream_if.source       o_rsp
);

    // The store is a 256 x 256 vertex grid split into four banks by the parity of the
    // row and the column. The four corners of any cell always fall into four different
    // banks, so a query reads all of them in the same cycle with a single read port per bank.
    //
    // Pipeline stages (each holds one item, with its own valid and stall logic):
    //   s1  clamped indices, fractions and edge flags (computed from the input item)
    //   s2  bank read data; writes are committed on the way into this stage
    //   s3  corner heights and differences along X
    //   s4  products of the differences with the X fraction
    //   s5  the two blended rows
    //   s6  difference along Z
    //   s7  product with the Z fraction
    //   out result register
    //
    // Each blend a*(1-f) + b*f with floor rounding is computed as a + floor((b-a)*f),
    // which is exact because a*ONE is a multiple of ONE. This needs one multiplier
    // per blend instead of two.

    localparam int CellLimInt = (MAX_CELLS > 255) ? 255 : MAX_CELLS;
    localparam logic [IDX_W-1:0] CELL_LIM = IDX_W'(CellLimInt);
    localparam int DiffW = HEIGHT_W + 1;
    localparam int ProdW = DiffW + FRAC_BITS + 1;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] r_cells_x;
    logic [CFG_W-1:0] r_cells_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cells_x <= CELLS_RESET;
            r_cells_z <= CELLS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CELLS_X: r_cells_x <= i_cfg_data;
                CFG_CELLS_Z: r_cells_z <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // A count of zero acts as one cell, and counts above the limit saturate.
    logic [IDX_W-1:0] cells_x_eff;
    logic [IDX_W-1:0] cells_z_eff;

    always_comb begin
        if (r_cells_x == '0) begin
            cells_x_eff = IDX_W'(1);
        end else if (r_cells_x > CELL_LIM) begin
            cells_x_eff = CELL_LIM;
        end else begin
            cells_x_eff = r_cells_x;
        end
        if (r_cells_z == '0) begin
            cells_z_eff = IDX_W'(1);
        end else if (r_cells_z > CELL_LIM) begin
            cells_z_eff = CELL_LIM;
        end else begin
            cells_z_eff = r_cells_z;
        end
    end

    // ------------------------------------------------------------------
    // Stall chain: a stage takes a new item when it is empty or its item moves on.
    // ------------------------------------------------------------------
    logic r_s1_v, r_s2_v, r_s3_v, r_s4_v, r_s5_v, r_s6_v, r_s7_v, r_out_v;
    logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_s6, rdy_s7, rdy_out;

    assign rdy_out = !r_out_v || o_rsp.ready;
    assign rdy_s7  = !r_s7_v  || rdy_out;
    assign rdy_s6  = !r_s6_v  || rdy_s7;
    assign rdy_s5  = !r_s5_v  || rdy_s6;
    assign rdy_s4  = !r_s4_v  || rdy_s5;
    assign rdy_s3  = !r_s3_v  || rdy_s4;
    assign rdy_s2  = !r_s2_v  || rdy_s3;
    assign rdy_s1  = !r_s1_v  || rdy_s2;

    assign i_req.ready = rdy_s1;

    // ------------------------------------------------------------------
    // Stage 1: clamp the position to [0, cells] and split it into index and fraction.
    // ------------------------------------------------------------------
    logic signed [POS_W:0]   top_x, top_z, pos_x, pos_z;
    logic [POS_W-1:0]        clamp_x, clamp_z;
    logic [IDX_W-1:0]        n_ix, n_iz;

    always_comb begin
        top_x = $signed({1'b0, POS_W'(POS_W'(cells_x_eff) << FRAC_BITS)});
        top_z = $signed({1'b0, POS_W'(POS_W'(cells_z_eff) << FRAC_BITS)});
        pos_x = (POS_W + 1)'(i_req.payload.query_x);
        pos_z = (POS_W + 1)'(i_req.payload.query_z);

        if (pos_x < 0) begin
            clamp_x = '0;
        end else if (pos_x > top_x) begin
            clamp_x = top_x[POS_W-1:0];
        end else begin
            clamp_x = pos_x[POS_W-1:0];
        end

        if (pos_z < 0) begin
            clamp_z = '0;
        end else if (pos_z > top_z) begin
            clamp_z = top_z[POS_W-1:0];
        end else begin
            clamp_z = pos_z[POS_W-1:0];
        end

        n_ix = clamp_x[FRAC_BITS +: IDX_W];
        n_iz = clamp_z[FRAC_BITS +: IDX_W];
    end

    logic                 r_s1_op;
    logic [IDX_W-1:0]     r_s1_col, r_s1_row;
    logic [HEIGHT_W-1:0]  r_s1_hin;
    logic [IDX_W-1:0]     r_s1_ix, r_s1_iz;
    logic [FRAC_BITS-1:0] r_s1_fx, r_s1_fz;
    logic                 r_s1_ex, r_s1_ez;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (rdy_s1) begin
            r_s1_v <= i_req.valid;
        end
        if (rdy_s1) begin
            r_s1_op  <= i_req.payload.opcode;
            r_s1_col <= i_req.payload.write_col;
            r_s1_row <= i_req.payload.write_row;
            r_s1_hin <= i_req.payload.height_in;
            r_s1_ix  <= n_ix;
            r_s1_iz  <= n_iz;
            r_s1_fx  <= clamp_x[FRAC_BITS-1:0];
            r_s1_fz  <= clamp_z[FRAC_BITS-1:0];
            // At the far edge the neighbor index is capped, so it equals the index.
            r_s1_ex  <= (n_ix == cells_x_eff);
            r_s1_ez  <= (n_iz == cells_z_eff);
        end
    end

    // ------------------------------------------------------------------
    // Store access: one write or four reads as the item moves into stage 2.
    // ------------------------------------------------------------------
    logic s1_wr, s1_rd;
    logic [IDX_W-1:0] iz_next, ix_next;
    logic signed [HEIGHT_W-1:0] bank_q [NUM_BANK];

    assign s1_wr   = rdy_s2 && r_s1_v && (r_s1_op == OP_WRITE);
    assign s1_rd   = rdy_s2 && r_s1_v && (r_s1_op == OP_QUERY);
    assign iz_next = r_s1_iz + IDX_W'(1);
    assign ix_next = r_s1_ix + IDX_W'(1);

    for (genvar b = 0; b < NUM_BANK; b++) begin : g_bank
        localparam logic [1:0] Bid = 2'(b);
        logic [IDX_W-1:0]   rd_row, rd_col;
        logic               wr_hit;
        logic [BANK_AW-1:0] rd_addr, wr_addr;
        logic [HEIGHT_W-1:0] q;

        // The bank of a given row and column parity holds either the cell's own
        // row (column) or the next one, depending on the cell index parity.
        assign rd_row  = (r_s1_iz[0] == Bid[1]) ? r_s1_iz : iz_next;
        assign rd_col  = (r_s1_ix[0] == Bid[0]) ? r_s1_ix : ix_next;
        assign rd_addr = {rd_row[IDX_W-1:1], rd_col[IDX_W-1:1]};
        assign wr_addr = {r_s1_row[IDX_W-1:1], r_s1_col[IDX_W-1:1]};
        assign wr_hit  = ({r_s1_row[0], r_s1_col[0]} == Bid);

        hbs_bank #(
            .AW (BANK_AW),
            .DW (HEIGHT_W)
        ) u_bank (
            .i_clk   (i_clk),
            .i_we    (s1_wr && wr_hit),
            .i_waddr (wr_addr),
            .i_wdata (r_s1_hin),
            .i_re    (s1_rd),
            .i_raddr (rd_addr),
            .o_rdata (q)
        );

        assign bank_q[b] = $signed(q);
    end

    // ------------------------------------------------------------------
    // Stage 2: read data is in the banks; only queries carry on from here.
    // ------------------------------------------------------------------
    logic                 r_s2_pz, r_s2_px, r_s2_ex, r_s2_ez;
    logic [FRAC_BITS-1:0] r_s2_fx, r_s2_fz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (rdy_s2) begin
            r_s2_v <= r_s1_v && (r_s1_op == OP_QUERY);
        end
        if (rdy_s2) begin
            r_s2_pz <= r_s1_iz[0];
            r_s2_px <= r_s1_ix[0];
            r_s2_ex <= r_s1_ex;
            r_s2_ez <= r_s1_ez;
            r_s2_fx <= r_s1_fx;
            r_s2_fz <= r_s1_fz;
        end
    end

    // Route the banks to the four corners. A capped neighbor takes the corner it
    // duplicates, so an entry past the edge is never used.
    logic [1:0] csel;
    logic signed [HEIGHT_W-1:0] raw10, raw01, raw11;
    logic signed [HEIGHT_W-1:0] h00, h10, h01, h11;

    always_comb begin
        csel  = {r_s2_pz, r_s2_px};
        h00   = bank_q[csel];
        raw10 = bank_q[csel ^ 2'b01];
        raw01 = bank_q[csel ^ 2'b10];
        raw11 = bank_q[csel ^ 2'b11];
        h10   = r_s2_ex ? h00 : raw10;
        h01   = r_s2_ez ? h00 : raw01;
        if (r_s2_ex) begin
            h11 = h01;
        end else if (r_s2_ez) begin
            h11 = raw10;
        end else begin
            h11 = raw11;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: differences along X.
    // ------------------------------------------------------------------
    logic signed [HEIGHT_W-1:0] r_s3_h00, r_s3_h01;
    logic signed [DiffW-1:0]    r_s3_d0, r_s3_d1;
    logic [FRAC_BITS-1:0]       r_s3_fx, r_s3_fz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_v <= 1'b0;
        end else if (rdy_s3) begin
            r_s3_v <= r_s2_v;
        end
        if (rdy_s3) begin
            r_s3_h00 <= h00;
            r_s3_h01 <= h01;
            r_s3_d0  <= DiffW'(h10) - DiffW'(h00);
            r_s3_d1  <= DiffW'(h11) - DiffW'(h01);
            r_s3_fx  <= r_s2_fx;
            r_s3_fz  <= r_s2_fz;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: scale the X differences by the X fraction.
    // ------------------------------------------------------------------
    logic signed [HEIGHT_W-1:0] r_s4_h00, r_s4_h01;
    logic signed [ProdW-1:0]    r_s4_p0, r_s4_p1;
    logic [FRAC_BITS-1:0]       r_s4_fz;
    logic signed [FRAC_BITS:0]  s3_fx_s;

    assign s3_fx_s = $signed({1'b0, r_s3_fx});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_v <= 1'b0;
        end else if (rdy_s4) begin
            r_s4_v <= r_s3_v;
        end
        if (rdy_s4) begin
            r_s4_h00 <= r_s3_h00;
            r_s4_h01 <= r_s3_h01;
            r_s4_p0  <= ProdW'(r_s3_d0) * ProdW'(s3_fx_s);
            r_s4_p1  <= ProdW'(r_s3_d1) * ProdW'(s3_fx_s);
            r_s4_fz  <= r_s3_fz;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: the two rows blended along X (floor by arithmetic shift).
    // ------------------------------------------------------------------
    logic signed [HEIGHT_W-1:0] r_s5_h0, r_s5_h1;
    logic [FRAC_BITS-1:0]       r_s5_fz;
    logic signed [ProdW-1:0]    s4_h0_w, s4_h1_w;

    assign s4_h0_w = ProdW'(r_s4_h00) + (r_s4_p0 >>> FRAC_BITS);
    assign s4_h1_w = ProdW'(r_s4_h01) + (r_s4_p1 >>> FRAC_BITS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_v <= 1'b0;
        end else if (rdy_s5) begin
            r_s5_v <= r_s4_v;
        end
        if (rdy_s5) begin
            // A convex blend of two 24-bit heights always fits 24 bits.
            r_s5_h0 <= s4_h0_w[HEIGHT_W-1:0];
            r_s5_h1 <= s4_h1_w[HEIGHT_W-1:0];
            r_s5_fz <= r_s4_fz;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: difference along Z.
    // ------------------------------------------------------------------
    logic signed [HEIGHT_W-1:0] r_s6_h0;
    logic signed [DiffW-1:0]    r_s6_dz;
    logic [FRAC_BITS-1:0]       r_s6_fz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6_v <= 1'b0;
        end else if (rdy_s6) begin
            r_s6_v <= r_s5_v;
        end
        if (rdy_s6) begin
            r_s6_h0 <= r_s5_h0;
            r_s6_dz <= DiffW'(r_s5_h1) - DiffW'(r_s5_h0);
            r_s6_fz <= r_s5_fz;
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: scale the Z difference by the Z fraction.
    // ------------------------------------------------------------------
    logic signed [HEIGHT_W-1:0] r_s7_h0;
    logic signed [ProdW-1:0]    r_s7_pz;
    logic signed [FRAC_BITS:0]  s6_fz_s;

    assign s6_fz_s = $signed({1'b0, r_s6_fz});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s7_v <= 1'b0;
        end else if (rdy_s7) begin
            r_s7_v <= r_s6_v;
        end
        if (rdy_s7) begin
            r_s7_h0 <= r_s6_h0;
            r_s7_pz <= ProdW'(r_s6_dz) * ProdW'(s6_fz_s);
        end
    end

    // ------------------------------------------------------------------
    // Output register: final blend along Z.
    // ------------------------------------------------------------------
    t_rsp                    r_out;
    logic signed [ProdW-1:0] s7_h_w;

    assign s7_h_w = ProdW'(r_s7_h0) + (r_s7_pz >>> FRAC_BITS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (rdy_out) begin
            r_out_v <= r_s7_v;
        end
        if (rdy_out) begin
            r_out.height_out <= s7_h_w[HEIGHT_W-1:0];
        end
    end

    assign o_rsp.valid   = r_out_v;
    assign o_rsp.payload = r_out;

endmodule

// ===== design/hbs_bank.sv =====
module hbs_bank
    import hbs_pkg::*;
#(
    parameter int AW = 14,
    parameter int DW = 24
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] mem [2**AW];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Read data holds while the consuming stage is stalled.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
